// ----- sv/crik_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register indexes, reset values and vector types for the
// cable robot inverse kinematics block. Depends on nothing else.
package crik_pkg;

   localparam int FRAC_BITS = 16;

   localparam int REG_W   = 17;
   localparam int POS_W   = 18;
   localparam int LEN_W   = 18;
   localparam int DIFF_W  = POS_W + 1;
   localparam int SQ_W    = 2 * (DIFF_W - 1);
   localparam int SUM_W   = SQ_W + 2;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int REM_W   = ROOT_W + 4;
   localparam int NUM_CABLES   = 4;
   localparam int SQRT_STAGES  = ROOT_W;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HALF_SPAN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULLEY_INSET    = 2'd1;

   localparam logic [REG_W-1:0] REG_MAX = '1;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // Reset values: round(0.715 m) and round(0.05 m) in the fixed-point format.
   localparam logic [63:0] SPAN_RAW  = ((64'd715 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam logic [63:0] INSET_RAW = ((64'd50 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam logic [REG_W-1:0] SPAN_RESET =
      (SPAN_RAW > 64'(REG_MAX)) ? REG_MAX : SPAN_RAW[REG_W-1:0];
   localparam logic [REG_W-1:0] INSET_RESET =
      (INSET_RAW > 64'(REG_MAX)) ? REG_MAX : INSET_RAW[REG_W-1:0];

   typedef logic [NUM_CABLES-1:0][SUM_W-1:0]  rad_vec_type;
   typedef logic [NUM_CABLES-1:0][REM_W-1:0]  rem_vec_type;
   typedef logic [NUM_CABLES-1:0][ROOT_W-1:0] root_vec_type;
   typedef logic [NUM_CABLES-1:0][LEN_W-1:0]  len_vec_type;

endpackage

// ----- sv/crik_isqrt.sv -----
`timescale 1ns / 1ps
// Four-lane pipelined floor square root, one result bit per stage, with
// saturation of each root to the length field. Depends on crik_pkg.
module crik_isqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  crik_pkg::rad_vec_type    in_rad,
   output logic                     out_valid,
   input  logic                     out_stall,
   output crik_pkg::len_vec_type    out_len
);
   import crik_pkg::*;

   localparam int LAST = SQRT_STAGES - 1;

   logic [SQRT_STAGES-1:0] valid_ff;
   logic [SQRT_STAGES-1:0] hold;
   rad_vec_type            rad_ff  [SQRT_STAGES-1];
   rem_vec_type            rem_ff  [SQRT_STAGES];
   root_vec_type           root_ff [SQRT_STAGES];

   genvar s;
   generate
      for (s = 0; s < SQRT_STAGES; s++) begin : stage_g
         logic         src_valid;
         rad_vec_type  src_rad;
         rem_vec_type  src_rem;
         root_vec_type src_root;
         rem_vec_type  rem_in;
         root_vec_type root_in;

         if (s == 0) begin : first_g
            assign src_valid = in_valid;
            assign src_rad   = in_rad;
            assign src_rem   = '0;
            assign src_root  = '0;
         end else begin : next_g
            assign src_valid = valid_ff[s-1];
            assign src_rad   = rad_ff[s-1];
            assign src_rem   = rem_ff[s-1];
            assign src_root  = root_ff[s-1];
         end

         // A stage holds when it is full and the stage after it cannot take it.
         if (s == LAST) begin : hold_last_g
            assign hold[s] = valid_ff[s] && out_stall;
         end else begin : hold_mid_g
            assign hold[s] = valid_ff[s] && hold[s+1];
         end

         always_comb begin
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            for (int l = 0; l < NUM_CABLES; l++) begin
               rem_sh = {src_rem[l][REM_W-3:0], src_rad[l][SUM_W-1 -: 2]};
               trial  = {{(REM_W-ROOT_W-2){1'b0}}, src_root[l], 2'b01};
               if (rem_sh >= trial) begin
                  rem_in[l]  = rem_sh - trial;
                  root_in[l] = {src_root[l][ROOT_W-2:0], 1'b1};
               end else begin
                  rem_in[l]  = rem_sh;
                  root_in[l] = {src_root[l][ROOT_W-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (!hold[s]) begin
               valid_ff[s] <= src_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (!hold[s] && src_valid) begin
               rem_ff[s]  <= rem_in;
               root_ff[s] <= root_in;
            end
         end

         if (s < LAST) begin : rad_g
            always_ff @(posedge clock) begin
               if (!hold[s] && src_valid) begin
                  rad_ff[s] <= src_rad << 2;
               end
            end
         end
      end
   endgenerate

   assign in_stall  = hold[0];
   assign out_valid = valid_ff[LAST];

   always_comb begin
      for (int l = 0; l < NUM_CABLES; l++) begin
         out_len[l] = root_ff[LAST][l][ROOT_W-1] ? LEN_MAX : root_ff[LAST][l][LEN_W-1:0];
      end
   end

   // The pipeline pushes back only when every stage holds an item.
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      in_stall |-> (&valid_ff))
      else $error("square root pipeline stalls with a bubble inside");

   // A finished root leaves a remainder of at most twice the root.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |->
         (rem_ff[LAST][0] <= {{(REM_W-ROOT_W-1){1'b0}}, root_ff[LAST][0], 1'b0}) &&
         (rem_ff[LAST][1] <= {{(REM_W-ROOT_W-1){1'b0}}, root_ff[LAST][1], 1'b0}) &&
         (rem_ff[LAST][2] <= {{(REM_W-ROOT_W-1){1'b0}}, root_ff[LAST][2], 1'b0}) &&
         (rem_ff[LAST][3] <= {{(REM_W-ROOT_W-1){1'b0}}, root_ff[LAST][3], 1'b0}))
      else $error("square root remainder out of range");

   a_entry_taken: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !in_stall) |=> valid_ff[0])
      else $error("accepted radicand did not enter the first stage");

endmodule

// ----- sv/cable_robot_inverse_kinematics.sv -----
`timescale 1ns / 1ps
// Top level of the cable robot inverse kinematics block: configuration
// registers, differences, squares and sums. Depends on crik_pkg, crik_isqrt.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_pos_x, req_pos_y, req_pos_z
//   rsp_      out        rsp_valid/rsp_stall   rsp_len_{pos,neg}_{x,y}_anchor
//   csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One point is taken per cycle while req_stall is low; a point passes the difference, square
// and sum stages, then 19 square root stages of one root bit each.
// Synchronous reset clears all valid bits and loads the default geometry.
// A stall on rsp_ holds the last stage; earlier stages keep filling bubbles,
// and req_stall rises only once every stage holds a point.
module cable_robot_inverse_kinematics (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [crik_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [crik_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [crik_pkg::POS_W-1:0]    req_pos_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [crik_pkg::LEN_W-1:0]           rsp_len_pos_x_anchor,
   output logic [crik_pkg::LEN_W-1:0]           rsp_len_pos_y_anchor,
   output logic [crik_pkg::LEN_W-1:0]           rsp_len_neg_x_anchor,
   output logic [crik_pkg::LEN_W-1:0]           rsp_len_neg_y_anchor,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [crik_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [crik_pkg::REG_W-1:0]           csr_wdata
);
   import crik_pkg::*;

   logic [REG_W-1:0] span_ff;
   logic [REG_W-1:0] inset_ff;

   logic hold1, hold2, hold3;
   logic v1_ff, v2_ff, v3_ff;

   logic signed [POS_W-1:0]  anchor;
   logic signed [DIFF_W-1:0] anchor_w;
   logic signed [DIFF_W-1:0] x_w, y_w, z_w;

   logic signed [DIFF_W-1:0] dxp_ff, dxn_ff, dx_ff, dy_ff, dyp_ff, dyn_ff, dz_ff;
   logic signed [2*DIFF_W-1:0] pxp, pxn, px, py, pyp, pyn, pz;
   logic [SQ_W-1:0] sxp_ff, sxn_ff, sx_ff, sy_ff, syp_ff, syn_ff, sz_ff;
   rad_vec_type     sum_ff;

   logic        sqrt_stall;
   len_vec_type len;

   // Configuration port: always ready, writes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff  <= SPAN_RESET;
         inset_ff <= INSET_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_HALF_SPAN: span_ff  <= csr_wdata;
            CSR_PULLEY_INSET:    inset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // An inset larger than the span gives a negative anchor offset.
   assign anchor   = $signed({1'b0, span_ff}) - $signed({1'b0, inset_ff});
   assign anchor_w = {anchor[POS_W-1], anchor};
   assign x_w      = {req_pos_x[POS_W-1], req_pos_x};
   assign y_w      = {req_pos_y[POS_W-1], req_pos_y};
   assign z_w      = {req_pos_z[POS_W-1], req_pos_z};

   assign hold3     = v3_ff && sqrt_stall;
   assign hold2     = v2_ff && hold3;
   assign hold1     = v1_ff && hold2;
   assign req_stall = hold1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (!hold1) v1_ff <= req_valid;
         if (!hold2) v2_ff <= v1_ff;
         if (!hold3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold1 && req_valid) begin
         dxp_ff <= anchor_w - x_w;
         dxn_ff <= -anchor_w - x_w;
         dx_ff  <= x_w;
         dy_ff  <= y_w;
         dyp_ff <= anchor_w - y_w;
         dyn_ff <= -anchor_w - y_w;
         dz_ff  <= z_w;
      end
   end

   assign pxp = (2*DIFF_W)'(dxp_ff) * (2*DIFF_W)'(dxp_ff);
   assign pxn = (2*DIFF_W)'(dxn_ff) * (2*DIFF_W)'(dxn_ff);
   assign px  = (2*DIFF_W)'(dx_ff) * (2*DIFF_W)'(dx_ff);
   assign py  = (2*DIFF_W)'(dy_ff) * (2*DIFF_W)'(dy_ff);
   assign pyp = (2*DIFF_W)'(dyp_ff) * (2*DIFF_W)'(dyp_ff);
   assign pyn = (2*DIFF_W)'(dyn_ff) * (2*DIFF_W)'(dyn_ff);
   assign pz  = (2*DIFF_W)'(dz_ff) * (2*DIFF_W)'(dz_ff);

   always_ff @(posedge clock) begin
      if (!hold2 && v1_ff) begin
         sxp_ff <= pxp[SQ_W-1:0];
         sxn_ff <= pxn[SQ_W-1:0];
         sx_ff  <= px[SQ_W-1:0];
         sy_ff  <= py[SQ_W-1:0];
         syp_ff <= pyp[SQ_W-1:0];
         syn_ff <= pyn[SQ_W-1:0];
         sz_ff  <= pz[SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (!hold3 && v2_ff) begin
         sum_ff[0] <= {2'b00, sxp_ff} + {2'b00, sy_ff} + {2'b00, sz_ff};
         sum_ff[1] <= {2'b00, sx_ff} + {2'b00, syp_ff} + {2'b00, sz_ff};
         sum_ff[2] <= {2'b00, sxn_ff} + {2'b00, sy_ff} + {2'b00, sz_ff};
         sum_ff[3] <= {2'b00, sx_ff} + {2'b00, syn_ff} + {2'b00, sz_ff};
      end
   end

   crik_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_stall  (sqrt_stall),
      .in_rad    (sum_ff),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_len   (len)
   );

   assign rsp_len_pos_x_anchor = len[0];
   assign rsp_len_pos_y_anchor = len[1];
   assign rsp_len_neg_x_anchor = len[2];
   assign rsp_len_neg_y_anchor = len[3];

   a_req_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff))
      else $error("input pushed back while the front stages have room");

   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted point lost at the difference stage");

   a_square_moves: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !hold2) |=> v2_ff)
      else $error("point lost between the difference and square stages");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for cable_robot_inverse_kinematics: end-effector points
// go in, four predicted cable lengths are checked per result. Depends on crik_pkg.
module tb_top;
   import crik_pkg::*;

   localparam int RUN_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;
   localparam int POS_MIN = -(1 << (POS_W - 1));
   localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
   // Indexes that decode to no register; writes to them must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic [LEN_W-1:0] pos_x;
      logic [LEN_W-1:0] pos_y;
      logic [LEN_W-1:0] neg_x;
      logic [LEN_W-1:0] neg_y;
   } cable_set_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_SPARSE}
      stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic signed [POS_W-1:0] req_pos_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [LEN_W-1:0] rsp_len_pos_x_anchor;
   logic [LEN_W-1:0] rsp_len_pos_y_anchor;
   logic [LEN_W-1:0] rsp_len_neg_x_anchor;
   logic [LEN_W-1:0] rsp_len_neg_y_anchor;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FRAME_HALF_SPAN;
   logic [REG_W-1:0] csr_wdata = '0;

   logic [REG_W-1:0] span_mirror = SPAN_RESET;
   logic [REG_W-1:0] inset_mirror = INSET_RESET;
   point_type pending_points[$];
   cable_set_type expected_lengths[$];
   point_type next_point;
   cable_set_type seen_lengths;
   cable_set_type want_lengths;
   int burst_left = 0;
   int gap_left = 0;
   int cycle_count = 0;
   int fail_count = 0;
   stall_mode_type stall_mode = STALL_NONE;

   cable_robot_inverse_kinematics u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_pos_z            (req_pos_z),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_len_pos_x_anchor (rsp_len_pos_x_anchor),
      .rsp_len_pos_y_anchor (rsp_len_pos_y_anchor),
      .rsp_len_neg_x_anchor (rsp_len_neg_x_anchor),
      .rsp_len_neg_y_anchor (rsp_len_neg_y_anchor),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Root is built from the top bit down; the sum of squares stays below 2^38.
   function automatic logic [31:0] floor_root(input longint radicand);
      longint root;
      longint trial;
      root = 0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= radicand)
            root = trial;
      end
      return 32'(root);
   endfunction

   function automatic logic [LEN_W-1:0] anchor_distance(input longint dx, input longint dy,
                                                        input longint dz);
      logic [31:0] root;
      root = floor_root(dx * dx + dy * dy + dz * dz);
      return (root > 32'(LEN_MAX)) ? LEN_MAX : root[LEN_W-1:0];
   endfunction

   function automatic cable_set_type predict_lengths(input point_type pt);
      cable_set_type lengths;
      longint a;
      longint x;
      longint y;
      longint z;
      a = longint'(span_mirror) - longint'(inset_mirror);
      x = longint'(pt.x);
      y = longint'(pt.y);
      z = longint'(pt.z);
      lengths.pos_x = anchor_distance(a - x, y, z);
      lengths.pos_y = anchor_distance(x, a - y, z);
      lengths.neg_x = anchor_distance(-a - x, y, z);
      lengths.neg_y = anchor_distance(x, -a - y, z);
      return lengths;
   endfunction

   function automatic logic signed [POS_W-1:0] random_coord(input int shape, input int reach);
      int v;
      case (shape)
         0, 1, 2, 3: v = $urandom;
         4, 5: v = int'($urandom_range(0, 256)) - 128;
         6: begin
            case ($urandom_range(0, 4))
               0: v = POS_MIN;
               1: v = POS_MAX;
               2: v = 0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         default: v = int'($urandom_range(0, 2 * reach)) - reach;
      endcase
      return POS_W'(v);
   endfunction

   task automatic queue_random_points(input int count);
      point_type pt;
      int a;
      int reach;
      int shape;
      a = int'(span_mirror) - int'(inset_mirror);
      reach = ((a < 0) ? -a : a) + 8192;
      for (int i = 0; i < count; i++) begin
         shape = $urandom_range(0, 9);
         pt.x = random_coord(shape, reach);
         pt.y = random_coord(shape, reach);
         pt.z = random_coord(shape, reach);
         // Near-anchor shape: small offsets around one of the four exit points.
         if (shape == 4 || shape == 5) begin
            case ($urandom_range(0, 3))
               0: pt.x = pt.x + POS_W'(a);
               1: pt.y = pt.y + POS_W'(a);
               2: pt.x = pt.x - POS_W'(a);
               default: pt.y = pt.y - POS_W'(a);
            endcase
         end
         pending_points.push_back(pt);
      end
   endtask

   task automatic queue_directed_points();
      int spots [17][3];
      int a;
      point_type pt;
      a = int'(span_mirror) - int'(inset_mirror);
      spots = '{'{0, 0, 0}, '{POS_MAX, POS_MAX, POS_MAX}, '{POS_MIN, POS_MIN, POS_MIN},
                '{POS_MIN, 0, 0}, '{POS_MAX, 0, 0}, '{0, POS_MIN, 0}, '{0, POS_MAX, 0},
                '{0, 0, POS_MIN}, '{0, 0, POS_MAX}, '{a, 0, 0}, '{0, a, 0}, '{-a, 0, 0},
                '{0, -a, 0}, '{-1, -1, -1}, '{1, 1, 1}, '{POS_MIN, POS_MAX, POS_MIN},
                '{POS_MAX, POS_MIN, POS_MAX}};
      for (int i = 0; i < 17; i++) begin
         pt.x = POS_W'(spots[i][0]);
         pt.y = POS_W'(spots[i][1]);
         pt.z = POS_W'(spots[i][2]);
         pending_points.push_back(pt);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FRAME_HALF_SPAN)
         span_mirror = value;
      else if (idx == CSR_PULLEY_INSET)
         inset_mirror = value;
   endtask

   task automatic drain();
      while (pending_points.size() != 0 || req_valid || expected_lengths.size() != 0)
         @(posedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps, some of them empty.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_lengths.push_back(
               predict_lengths(point_type'{req_pos_x, req_pos_y, req_pos_z}));
         if (req_valid && req_stall) begin
            // Stalled transfer: payload stays as it is.
         end else if (gap_left != 0 || pending_points.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left != 0)
               gap_left <= gap_left - 1;
         end else begin
            next_point = pending_points.pop_front();
            req_valid <= 1'b1;
            req_pos_x <= next_point.x;
            req_pos_y <= next_point.y;
            req_pos_z <= next_point.z;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Receiver: stall_mode is redrawn at random, and rsp_stall follows the current mode.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (cycle_count % 97 == 0)
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_COIN: rsp_stall <= ($urandom_range(0, 1) == 0);
            STALL_PERIODIC: rsp_stall <= (cycle_count % 5 < 2);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_lengths = '{rsp_len_pos_x_anchor, rsp_len_pos_y_anchor,
                          rsp_len_neg_x_anchor, rsp_len_neg_y_anchor};
         if (expected_lengths.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("cycle %0d: result with no point outstanding: %0d %0d %0d %0d",
                        cycle_count, seen_lengths.pos_x, seen_lengths.pos_y,
                        seen_lengths.neg_x, seen_lengths.neg_y);
         end else begin
            want_lengths = expected_lengths.pop_front();
            if (seen_lengths.pos_x !== want_lengths.pos_x ||
                seen_lengths.pos_y !== want_lengths.pos_y ||
                seen_lengths.neg_x !== want_lengths.neg_x ||
                seen_lengths.neg_y !== want_lengths.neg_y) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("cycle %0d: lengths +x +y -x -y expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                           cycle_count, want_lengths.pos_x, want_lengths.pos_y,
                           want_lengths.neg_x, want_lengths.neg_y, seen_lengths.pos_x,
                           seen_lengths.pos_y, seen_lengths.neg_x, seen_lengths.neg_y);
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Default geometry straight out of reset.
      queue_directed_points();
      queue_random_points(330);
      drain();

      // Widest anchor spacing; far points saturate.
      write_reg(CSR_FRAME_HALF_SPAN, REG_MAX);
      write_reg(CSR_PULLEY_INSET, '0);
      queue_random_points(300);
      drain();

      // Inset beyond the span mirrors the anchors through the origin.
      write_reg(CSR_FRAME_HALF_SPAN, '0);
      write_reg(CSR_PULLEY_INSET, REG_MAX);
      queue_random_points(300);
      drain();

      // All four anchors collapse onto the origin.
      write_reg(CSR_PULLEY_INSET, '0);
      queue_random_points(200);
      drain();

      for (int round = 0; round < 3; round++) begin
         write_reg(CSR_SPARE_LO, REG_W'($urandom));
         write_reg(CSR_SPARE_HI, REG_W'($urandom));
         write_reg(CSR_FRAME_HALF_SPAN, REG_W'($urandom_range(0, int'(REG_MAX))));
         write_reg(CSR_PULLEY_INSET, REG_W'($urandom_range(0, int'(REG_MAX) / 2)));
         queue_random_points(200);
         drain();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && expected_lengths.size() == 0)
         $display("cable_robot_inverse_kinematics verification clean");
      else
         $display("cable_robot_inverse_kinematics verification failed");
      $finish;
   end

   initial begin
      while (cycle_count < RUN_LIMIT)
         @(posedge clock);
      $display("cable_robot_inverse_kinematics verification failed");
      $finish;
   end

endmodule
